// File: rtl/msd_pkg.sv
package msd_pkg;

  // Longest code that can still decode; longer codes come out as unknown.
  localparam int MAX_CODE_SYMBOLS = 5;
  localparam int CODE_W = MAX_CODE_SYMBOLS;
  localparam int LEN_W = $clog2(MAX_CODE_SYMBOLS + 1);
  localparam int RUN_W = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] SLASH_CHAR = 8'd47;
  localparam logic [7:0] DOT_CHAR = 8'd46;
  localparam logic [7:0] DASH_CHAR = 8'd45;
  localparam logic [7:0] SPACE_CHAR = 8'd32;
  localparam logic [7:0] PERIOD_CHAR = 8'd46;
  localparam logic [7:0] UNKNOWN_CHAR = 8'd255;
  localparam logic [7:0] LETTER_BASE = 8'd65;
  localparam logic [7:0] DIGIT_BASE = 8'd48;
  localparam int NUM_LETTERS = 26;
  localparam int TABLE_SIZE = 36;

  localparam logic [RUN_W-1:0] SPACE_RUN = RUN_W'(3);
  localparam logic [RUN_W-1:0] PERIOD_RUN = RUN_W'(5);
  localparam logic [RUN_W-1:0] RUN_LIMIT = RUN_W'(7);

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END = 1'b1;

  // Code symbols, dot 0 and dash 1, first symbol most significant.
  localparam logic [7:0] MORSE_BITS [TABLE_SIZE] = '{
    8'b01, 8'b1000, 8'b1010, 8'b100, 8'b0, 8'b0010, 8'b110, 8'b0000, 8'b00,
    8'b0111, 8'b101, 8'b0100, 8'b11, 8'b10, 8'b111, 8'b0110, 8'b1101, 8'b010,
    8'b000, 8'b1, 8'b001, 8'b0001, 8'b011, 8'b1001, 8'b1011, 8'b1100,
    8'b11111, 8'b01111, 8'b00111, 8'b00011, 8'b00001, 8'b00000, 8'b10000,
    8'b11000, 8'b11100, 8'b11110
  };
  localparam logic [7:0] MORSE_LEN [TABLE_SIZE] = '{
    8'd2, 8'd4, 8'd4, 8'd3, 8'd1, 8'd4, 8'd3, 8'd4, 8'd2,
    8'd4, 8'd3, 8'd4, 8'd2, 8'd2, 8'd3, 8'd4, 8'd4, 8'd3,
    8'd3, 8'd1, 8'd3, 8'd4, 8'd3, 8'd4, 8'd4, 8'd4,
    8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5,
    8'd5, 8'd5, 8'd5
  };

  typedef struct packed {
    logic [7:0] symbol;
    logic       final_symbol;
  } item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       kind;
    logic       message_end;
    logic       last_of_run;
  } result_t;

  // All results caused by one input beat; pair is set when two are held.
  typedef struct packed {
    logic    pair;
    result_t first;
    result_t second;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } qport_t;

  function automatic logic [7:0] decode(logic [CODE_W-1:0] pat,
                                        logic [LEN_W-1:0] len, logic bad);
    logic [7:0] ch;
    ch = UNKNOWN_CHAR;
    if (!bad && len != '0) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        if (MORSE_LEN[i] == 8'(len) && MORSE_BITS[i] == 8'(pat)) begin
          ch = (i < NUM_LETTERS) ? 8'(int'(LETTER_BASE) + i)
                                 : 8'(int'(DIGIT_BASE) + i - NUM_LETTERS);
        end
      end
    end
    return ch;
  endfunction

endpackage

// File: rtl/morse_code_stream_decoder.sv
// Morse stream decoder. Message bytes enter as beats on the push/full side
// ('.' and '-' build a code, '/' separates, any other byte spoils the code;
// final_symbol marks the last byte), and decoded characters leave on the
// empty/pop side. The front stage takes one beat per cycle whenever full is
// low: it updates the pending code and slash-run count in the same cycle and
// forms all results of the beat (none, one or two) as a single queue entry.
// A two-entry queue separates it from the back stage, which hands out one
// result per pop, so a beat that makes k results takes k pops; the
// sustained rate is set by that single output register, one result per
// cycle while pop stays high, and input never stalls while the queue has
// room. Unknown, too long or empty codes give 255; three slashes give a
// space and five a period, both when the run ends. A final byte flushes
// the code, or, if nothing else comes out, yields a marker with kind set
// and character zero; the last result of the final beat carries message_end.
// On an empty block a beat's first result is written to the queue on
// accept, then loaded into the output register, from which it is popped.
module morse_code_stream_decoder (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  msd_pkg::item_t   item,
  output logic             empty,
  input  logic             pop,
  output msd_pkg::result_t result
);

  msd_pkg::qport_t wr;    // entry from the front stage
  msd_pkg::qport_t head;  // oldest queued entry
  logic            rd;
  logic            accept;

  // beat accepted when the queue can take whatever it produces
  assign accept = push & ~full;

  msd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .wr     (wr)
  );

  msd_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .rd   (rd),
    .head (head),
    .full (full)
  );

  msd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .rd     (rd),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

endmodule

// File: rtl/msd_front.sv
module msd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  msd_pkg::item_t  item,
  output msd_pkg::qport_t wr
);

  logic [msd_pkg::CODE_W-1:0] code_pattern, code_pattern_next;
  logic [msd_pkg::LEN_W-1:0]  code_length, code_length_next;
  logic                       code_invalid, code_invalid_next;
  logic [msd_pkg::RUN_W-1:0]  slash_run, slash_run_next;

  logic                       is_slash, is_dot, is_dash, last;
  logic                       run_emit;
  logic [7:0]                 run_char;
  logic [msd_pkg::RUN_W-1:0]  run_inc;
  logic [msd_pkg::CODE_W-1:0] add_pattern;
  logic [msd_pkg::LEN_W-1:0]  add_length;
  logic                       add_invalid;
  logic [7:0]                 dec_old, dec_new;
  msd_pkg::result_t           res_a, res_b;

  always_comb begin
    is_slash = item.symbol == msd_pkg::SLASH_CHAR;
    is_dot   = item.symbol == msd_pkg::DOT_CHAR;
    is_dash  = item.symbol == msd_pkg::DASH_CHAR;
    last     = item.final_symbol;
    run_inc  = (slash_run == msd_pkg::RUN_LIMIT) ? slash_run
                                                 : msd_pkg::RUN_W'(slash_run + 1'b1);

    // code with this beat's symbol appended
    add_invalid = code_invalid | ~(is_dot | is_dash);
    add_pattern = code_pattern;
    add_length  = code_length;
    if (code_length < msd_pkg::LEN_W'(msd_pkg::MAX_CODE_SYMBOLS)) begin
      add_pattern = {code_pattern[msd_pkg::CODE_W-2:0], is_dash};
      add_length  = msd_pkg::LEN_W'(code_length + 1'b1);
    end else begin
      add_invalid = 1'b1;
    end

    dec_old = msd_pkg::decode(code_pattern, code_length, code_invalid);
    dec_new = msd_pkg::decode(add_pattern, add_length, add_invalid);

    code_pattern_next = code_pattern;
    code_length_next  = code_length;
    code_invalid_next = code_invalid;
    slash_run_next    = slash_run;
    wr       = '0;
    res_a    = '0;
    res_b    = '0;
    run_emit = 1'b0;
    run_char = msd_pkg::SPACE_CHAR;

    if (is_slash) begin
      if (slash_run == '0) begin
        res_a.character   = dec_old;
        res_a.kind        = msd_pkg::KIND_CHAR;
        res_a.last_of_run = 1'b1;
        res_a.message_end = last;
        wr.valid          = 1'b1;
        code_pattern_next = '0;
        code_length_next  = '0;
        code_invalid_next = 1'b0;
        slash_run_next    = msd_pkg::RUN_W'(1);
      end else begin
        slash_run_next = run_inc;
        if (last) begin
          wr.valid          = 1'b1;
          res_a.last_of_run = 1'b1;
          res_a.message_end = 1'b1;
          if (run_inc == msd_pkg::SPACE_RUN) begin
            res_a.character = msd_pkg::SPACE_CHAR;
            res_a.kind      = msd_pkg::KIND_CHAR;
          end else if (run_inc == msd_pkg::PERIOD_RUN) begin
            res_a.character = msd_pkg::PERIOD_CHAR;
            res_a.kind      = msd_pkg::KIND_CHAR;
          end else begin
            res_a.character = '0;
            res_a.kind      = msd_pkg::KIND_END;
          end
        end
      end
    end else begin
      // a code symbol first closes any slash run
      run_emit = (slash_run == msd_pkg::SPACE_RUN) || (slash_run == msd_pkg::PERIOD_RUN);
      if (slash_run == msd_pkg::PERIOD_RUN) run_char = msd_pkg::PERIOD_CHAR;
      slash_run_next    = '0;
      code_pattern_next = add_pattern;
      code_length_next  = add_length;
      code_invalid_next = add_invalid;
      if (last) begin
        res_b.character   = dec_new;
        res_b.kind        = msd_pkg::KIND_CHAR;
        res_b.last_of_run = 1'b1;
        res_b.message_end = 1'b1;
        wr.valid          = 1'b1;
        if (run_emit) begin
          res_a.character = run_char;
          res_a.kind      = msd_pkg::KIND_CHAR;
          wr.entry.pair   = 1'b1;
        end else begin
          res_a = res_b;
        end
      end else if (run_emit) begin
        res_a.character   = run_char;
        res_a.kind        = msd_pkg::KIND_CHAR;
        res_a.last_of_run = 1'b1;
        wr.valid          = 1'b1;
      end
    end

    if (last) begin
      code_pattern_next = '0;
      code_length_next  = '0;
      code_invalid_next = 1'b0;
      slash_run_next    = '0;
    end

    wr.entry.first  = res_a;
    wr.entry.second = res_b;
    wr.valid        = wr.valid & accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_pattern <= '0;
      code_length  <= '0;
      code_invalid <= 1'b0;
      slash_run    <= '0;
    end else if (accept) begin
      code_pattern <= code_pattern_next;
      code_length  <= code_length_next;
      code_invalid <= code_invalid_next;
      slash_run    <= slash_run_next;
    end
  end

endmodule

// File: rtl/msd_queue.sv
module msd_queue (
  input  logic            clk,
  input  logic            rst,
  input  msd_pkg::qport_t wr,
  input  logic            rd,
  output msd_pkg::qport_t head,
  output logic            full
);

  msd_pkg::entry_t             mem [msd_pkg::QUEUE_DEPTH];
  logic [msd_pkg::QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [msd_pkg::QCNT_W-1:0]  count;
  logic                        do_rd;

  assign full       = count == msd_pkg::QCNT_W'(msd_pkg::QUEUE_DEPTH);
  assign head.valid = count != '0;
  assign head.entry = mem[rd_ptr];
  assign do_rd      = rd & head.valid;

  always_ff @(posedge clk) begin
    if (wr.valid) mem[wr_ptr] <= wr.entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr.valid) wr_ptr <= msd_pkg::QPTR_W'(wr_ptr + 1'b1);
      if (do_rd) rd_ptr <= msd_pkg::QPTR_W'(rd_ptr + 1'b1);
      if (wr.valid && !do_rd) count <= msd_pkg::QCNT_W'(count + 1'b1);
      else if (!wr.valid && do_rd) count <= msd_pkg::QCNT_W'(count - 1'b1);
    end
  end

endmodule

// File: rtl/msd_back.sv
module msd_back (
  input  logic             clk,
  input  logic             rst,
  input  msd_pkg::qport_t  head,
  output logic             rd,
  input  logic             pop,
  output logic             empty,
  output msd_pkg::result_t result
);

  msd_pkg::entry_t cur;
  logic            valid;
  logic            idx;
  logic            taken, at_tail, advance;

  assign empty   = ~valid;
  assign result  = idx ? cur.second : cur.first;
  assign taken   = pop & valid;
  assign at_tail = ~cur.pair | idx;
  assign advance = ~valid | (taken & at_tail);
  assign rd      = advance & head.valid;

  always_ff @(posedge clk) begin
    if (rd) cur <= head.entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 1'b0;
    end else if (advance) begin
      valid <= head.valid;
      idx   <= 1'b0;
    end else if (taken) begin
      idx <= 1'b1;
    end
  end

endmodule

// File: rtl/msd_checker.sv
module msd_checker (
  input logic             clk,
  input logic             rst,
  input logic             push,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input msd_pkg::result_t result
);

  // reset leaves nothing to read and room to write
  a_reset_idle: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (empty && !full))
    else $error("block not idle after reset");

  // a message end closes the run of results of its beat
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.message_end) |-> result.last_of_run)
    else $error("message_end without last_of_run");

  // end marker is bare and always ends the message
  a_marker_form: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.kind == msd_pkg::KIND_END) |->
      (result.character == 8'd0 && result.message_end))
    else $error("malformed end marker");

  // a waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("result changed while stalled");

endmodule

bind morse_code_stream_decoder msd_checker u_msd_checker (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
